[design/assert_macros.svh]
// Assertion macros shared by the ring buffer FIFO modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RBFO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring buffer FIFO assertion violated");

// Next-cycle implication, checked at every rising edge outside reset.
`define RBFO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring buffer FIFO assertion violated");

`endif

[design/rbfo_pkg.sv]
// Shared types and constants for the ring buffer FIFO with overwrite.
`default_nettype none

package rbfo_pkg;

  localparam int unsigned CFG_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PIDX_W = 4;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef struct packed {
    func_t               func;
    logic                overwrite_if_full;
    logic [DATA_W-1:0]   push_data;
    logic [PIDX_W-1:0]   peek_index;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic [DATA_W-1:0]   read_data;
    logic                empty_res;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic cfg_we;
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

`default_nettype wire

[design/ring_buffer_fifo_with_overwrite_core.sv]
// A result beat is offered once its input beat has been accepted, executed and
// registered. Input beats are taken only in idle, when the slot memory is read,
// so a new item waits while one is in execute; a stalled result holds execute.
// Reset (rst_n, synchronous): head and tail return to slot 0, the slot count to
// DEPTH, and no result is pending; slot memory contents are left as they are.
// Top level of the ring buffer FIFO with overwrite.
`default_nettype none

module ring_buffer_fifo_with_overwrite_core #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rbfo_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rbfo_pkg::out_item_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rbfo_pkg::CFG_W-1:0]  cfg_data
);

  rbfo_pkg::cmd_t cmd;

  rbfo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  rbfo_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[design/rbfo_ctrl.sv]
// Controller state machine that sequences accept, execute and result hand-off.
`default_nettype none
`include "assert_macros.svh"

module rbfo_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  output rbfo_pkg::cmd_t    cmd
);

  rbfo_pkg::state_t state_r;
  rbfo_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbfo_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rbfo_pkg::ST_EXEC;
        end
      end
      rbfo_pkg::ST_EXEC: begin
        if (out_free) begin
          state_nxt = rbfo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rbfo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    cmd.cfg_we = 1'b0;
    unique case (state_r)
      rbfo_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cfg_ready  = 1'b1;
        cmd.load   = in_valid;
        cmd.cfg_we = cfg_valid;
      end
      rbfo_pkg::ST_EXEC: begin
        cmd.commit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbfo_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RBFO_ASSERT_NEXT(a_load_enters_exec, cmd.load, state_r == rbfo_pkg::ST_EXEC)
  `RBFO_ASSERT_NEXT(a_commit_gives_beat, cmd.commit, out_valid_r)
  `RBFO_ASSERT_NEXT(a_exec_waits_for_room,
                    state_r == rbfo_pkg::ST_EXEC && out_valid_r && out_stall,
                    state_r == rbfo_pkg::ST_EXEC)

endmodule

`default_nettype wire

[design/rbfo_dp.sv]
// Datapath with slot memory, head and tail pointers, slot count and result register.
`default_nettype none
`include "assert_macros.svh"

module rbfo_dp #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rbfo_pkg::cmd_t              cmd,
  input  wire logic [rbfo_pkg::CFG_W-1:0]  cfg_data,
  input  wire rbfo_pkg::in_item_t          in_data,
  output rbfo_pkg::out_item_t              out_data
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam int unsigned AW = ((NW > rbfo_pkg::CFG_W) ? NW : rbfo_pkg::CFG_W) + 1;
  localparam int unsigned MW = (WIDTH < rbfo_pkg::DATA_W) ? WIDTH : rbfo_pkg::DATA_W;

  logic [MW-1:0] mem [DEPTH];

  logic [IW-1:0]        head_r, head_nxt;
  logic [IW-1:0]        tail_r, tail_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  rbfo_pkg::in_item_t   item_r;
  logic [MW-1:0]        rdata_r;
  rbfo_pkg::out_item_t  out_r, out_nxt;

  logic [AW-1:0]        n_ext;
  logic [AW-1:0]        cfg_ext;
  logic [AW-1:0]        peek_sum;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        head_adv, tail_adv;
  logic [AW-1:0]        count;
  logic                 full;
  logic                 ok;
  logic                 wr_en;
  logic                 rd_sel;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] x, input logic [AW-1:0] n);
    logic [AW-1:0] nx;
    nx = AW'(x) + AW'(1);
    return (nx == n) ? '0 : nx[IW-1:0];
  endfunction

  assign n_ext = AW'(n_r);

  always_comb begin
    cfg_ext = AW'(cfg_data);
    if (cfg_ext < AW'(2)) begin
      n_nxt = NW'(2);
    end else if (cfg_ext > AW'(DEPTH)) begin
      n_nxt = NW'(DEPTH);
    end else begin
      n_nxt = cfg_ext[NW-1:0];
    end
  end

  always_comb begin
    peek_sum = AW'(head_r);
    if (in_data.func == rbfo_pkg::FUNC_PEEK) begin
      peek_sum = AW'(head_r) + AW'(in_data.peek_index);
    end
    if (peek_sum >= n_ext) begin
      peek_sum = peek_sum - n_ext;
    end
    rd_addr = peek_sum[IW-1:0];
  end

  assign head_adv = adv(head_r, n_ext);
  assign tail_adv = adv(tail_r, n_ext);
  assign full     = (tail_adv == head_r);

  always_comb begin
    if (tail_r >= head_r) begin
      count = AW'(tail_r) - AW'(head_r);
    end else begin
      count = AW'(tail_r) + n_ext - AW'(head_r);
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    ok       = 1'b0;
    wr_en    = 1'b0;
    rd_sel   = 1'b0;
    unique case (item_r.func)
      rbfo_pkg::FUNC_PUSH: begin
        if (!full || item_r.overwrite_if_full) begin
          ok       = 1'b1;
          wr_en    = 1'b1;
          tail_nxt = tail_adv;
          if (full) begin
            head_nxt = head_adv;
          end
        end
      end
      rbfo_pkg::FUNC_POP: begin
        if (head_r != tail_r) begin
          ok       = 1'b1;
          rd_sel   = 1'b1;
          head_nxt = head_adv;
        end
      end
      rbfo_pkg::FUNC_PEEK: begin
        if (AW'(item_r.peek_index) < count) begin
          ok     = 1'b1;
          rd_sel = 1'b1;
        end
      end
      rbfo_pkg::FUNC_CLEAR: begin
        ok       = 1'b1;
        head_nxt = '0;
        tail_nxt = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    out_nxt.ok        = ok;
    out_nxt.read_data = rd_sel ? rbfo_pkg::DATA_W'(rdata_r) : '0;
    out_nxt.empty_res = (head_nxt == tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      n_r    <= NW'(DEPTH);
    end else if (cmd.cfg_we) begin
      head_r <= '0;
      tail_r <= '0;
      n_r    <= n_nxt;
    end else if (cmd.commit) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r  <= in_data;
      rdata_r <= mem[rd_addr];
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[tail_r] <= item_r.push_data[MW-1:0];
    end
  end

  assign out_data = out_r;

  `RBFO_ASSERT_SAME(a_ptr_in_ring, 1'b1, (NW'(head_r) < n_r) && (NW'(tail_r) < n_r))
  `RBFO_ASSERT_NEXT(a_clear_resets_ptrs,
                    cmd.commit && item_r.func == rbfo_pkg::FUNC_CLEAR,
                    head_r == '0 && tail_r == '0)

endmodule

`default_nettype wire
